// ===== rtl/pndf_pkg.sv =====
// shared types and constants for the pareto non-dominated filter
// no dependencies; used by every module under rtl
`default_nettype none

package pndf_pkg;

	localparam int unsigned POP_MAX    = 64;
	localparam int unsigned MAX_OBJ    = 8;
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned ADDR_W     = $clog2(POP_MAX);
	localparam int unsigned CNT_W      = $clog2(POP_MAX + 1);
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned NOBJ_W     = 4;
	localparam logic [NOBJ_W-1:0] NOBJ_RESET = 4'd3;

	typedef struct packed {
		logic signed [31:0] obj_0;
		logic signed [31:0] obj_1;
		logic signed [31:0] obj_2;
		logic signed [31:0] obj_3;
		logic signed [31:0] obj_4;
		logic signed [31:0] obj_5;
		logic signed [31:0] obj_6;
		logic signed [31:0] obj_7;
		logic [31:0]        tag;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic [IDX_W-1:0]   point_index;
		logic signed [31:0] out_obj_0;
		logic signed [31:0] out_obj_1;
		logic signed [31:0] out_obj_2;
		logic signed [31:0] out_obj_3;
		logic signed [31:0] out_obj_4;
		logic signed [31:0] out_obj_5;
		logic signed [31:0] out_obj_6;
		logic signed [31:0] out_obj_7;
		logic [31:0]        out_tag;
		logic               last_result;
	} result_t;

	// one stored point: all objectives plus its tag
	typedef struct packed {
		logic [MAX_OBJ-1:0][VALUE_BITS-1:0] obj;
		logic [31:0]                        tag;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} store_req_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD_I,
		S_SWEEP,
		S_DRAIN,
		S_EMIT,
		S_FLUSH
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/pareto_nondominated_filter_top.sv =====
// pareto non-dominated filter, top level: load sequencer, sweep control, output register
// depends on pndf_pkg, pndf_store, pndf_dom_cmp
// results: after the beat with last_point the n points are filtered; results appear
//   spread over the filtering, the last one in the first cycle with busy low
// throughput: one point beat per cycle while loading; filtering is bound by the single
//   store read port, one point pair per cycle while sweeping (load, drain and emit steps lie between points)
// reset: arst_n clears the point count, state and strobes; num_objectives returns to 3
// results are one-cycle strobes; the receiver cannot stall
`default_nettype none

module pareto_nondominated_filter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// command side
	input  wire logic                           start,
	output logic                                busy,
	input  wire pndf_pkg::point_t               point,
	// result side
	output logic                                result_valid,
	output pndf_pkg::result_t                   result,
	// configuration: num_objectives
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [pndf_pkg::NOBJ_W-1:0]    cfg_data
);

	localparam int unsigned AW = pndf_pkg::ADDR_W;
	localparam int unsigned CW = pndf_pkg::CNT_W;
	localparam int unsigned IW = pndf_pkg::IDX_W;
	localparam int unsigned NW = pndf_pkg::NOBJ_W;

	pndf_pkg::state_t state_q, state_d;

	logic [NW-1:0] num_obj_q;
	logic [NW-1:0] n_eff;
	logic [CW-1:0] count_q;     // points stored for the current population
	logic [AW-1:0] i_q;         // point under test
	logic [AW-1:0] j_q;         // challenger read address
	logic          accept;
	logic          store_full;
	logic          j_end;
	logic          i_end;

	pndf_pkg::store_req_t req;
	pndf_pkg::entry_t     wr_entry;
	pndf_pkg::entry_t     rd_entry;

	// read pipeline markers, aligned with the store's registered read data
	logic          cap_s1;
	logic          cmp_v_s1;
	logic [AW-1:0] cmp_j_s1;

	pndf_pkg::entry_t pi_q;     // point under test, held through its sweep
	logic             dom_q;    // some challenger dominates point i
	logic             dom_hit;

	// one non-dominated point held back until we know whether it is the last
	logic             pend_v_q;
	pndf_pkg::entry_t pend_q;
	logic [AW-1:0]    pend_idx_q;

	logic emit_mid;
	logic emit_last;

	assign busy       = (state_q != pndf_pkg::S_IDLE);
	assign cfg_ready  = !busy;
	assign accept     = start && !busy;
	assign store_full = (count_q == CW'(pndf_pkg::POP_MAX));
	assign j_end      = ((CW'(j_q) + CW'(1)) == count_q);
	assign i_end      = ((CW'(i_q) + CW'(1)) == count_q);

	// objective count clamped into 1..MAX_OBJ
	always_comb begin
		if (num_obj_q == '0) begin
			n_eff = NW'(1);
		end else if (num_obj_q > NW'(pndf_pkg::MAX_OBJ)) begin
			n_eff = NW'(pndf_pkg::MAX_OBJ);
		end else begin
			n_eff = num_obj_q;
		end
	end

	// incoming beat into store format
	always_comb begin
		wr_entry.obj[0] = point.obj_0;
		wr_entry.obj[1] = point.obj_1;
		wr_entry.obj[2] = point.obj_2;
		wr_entry.obj[3] = point.obj_3;
		wr_entry.obj[4] = point.obj_4;
		wr_entry.obj[5] = point.obj_5;
		wr_entry.obj[6] = point.obj_6;
		wr_entry.obj[7] = point.obj_7;
		wr_entry.tag    = point.tag;
	end

	pndf_store u_store (
		.clk     (clk),
		.req     (req),
		.wr_data (wr_entry),
		.rd_data (rd_entry)
	);

	pndf_dom_cmp u_dom (
		.cand   (rd_entry),
		.ref_pt (pi_q),
		.n_obj  (n_eff),
		.dom    (dom_hit)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pndf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, store requests and emit strobes
	always_comb begin
		state_d      = state_q;
		req.wr_en    = 1'b0;
		req.wr_addr  = count_q[AW-1:0];
		req.rd_en    = 1'b0;
		req.rd_addr  = j_q;
		emit_mid     = 1'b0;
		emit_last    = 1'b0;
		case (state_q)
			pndf_pkg::S_IDLE: begin
				// a beat arriving on a full store is dropped
				req.wr_en = accept && !store_full;
				if (accept && point.last_point) begin
					state_d = pndf_pkg::S_LOAD_I;
				end
			end
			pndf_pkg::S_LOAD_I: begin
				req.rd_en   = 1'b1;
				req.rd_addr = i_q;
				state_d     = pndf_pkg::S_SWEEP;
			end
			pndf_pkg::S_SWEEP: begin
				req.rd_en   = 1'b1;
				req.rd_addr = j_q;
				if (j_end) begin
					state_d = pndf_pkg::S_DRAIN;
				end
			end
			pndf_pkg::S_DRAIN: begin
				// last challenger is compared in this cycle
				state_d = pndf_pkg::S_EMIT;
			end
			pndf_pkg::S_EMIT: begin
				emit_mid = !dom_q && pend_v_q;
				state_d  = i_end ? pndf_pkg::S_FLUSH : pndf_pkg::S_LOAD_I;
			end
			pndf_pkg::S_FLUSH: begin
				emit_last = pend_v_q;
				state_d   = pndf_pkg::S_IDLE;
			end
			default: begin
				state_d = pndf_pkg::S_IDLE;
			end
		endcase
	end

	// config register, counters and pipeline markers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_obj_q <= pndf_pkg::NOBJ_RESET;
			count_q   <= '0;
			i_q       <= '0;
			j_q       <= '0;
			cap_s1    <= 1'b0;
			cmp_v_s1  <= 1'b0;
			cmp_j_s1  <= '0;
			pend_v_q  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_obj_q <= cfg_data;
			end
			if (req.wr_en) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == pndf_pkg::S_IDLE) begin
				i_q <= '0;
			end else if (state_q == pndf_pkg::S_EMIT) begin
				i_q <= i_q + AW'(1);
			end
			if (state_q == pndf_pkg::S_SWEEP) begin
				j_q <= j_q + AW'(1);
			end else begin
				j_q <= '0;
			end
			cap_s1   <= (state_q == pndf_pkg::S_LOAD_I);
			cmp_v_s1 <= (state_q == pndf_pkg::S_SWEEP);
			cmp_j_s1 <= j_q;
			if (state_q == pndf_pkg::S_EMIT && !dom_q) begin
				pend_v_q <= 1'b1;
			end else if (state_q == pndf_pkg::S_FLUSH) begin
				pend_v_q <= 1'b0;
				count_q  <= '0;
			end
			result_valid <= emit_mid || emit_last;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (cap_s1) begin
			pi_q  <= rd_entry;
			dom_q <= 1'b0;
		end else if (cmp_v_s1 && (cmp_j_s1 != i_q) && dom_hit) begin
			dom_q <= 1'b1;
		end
		if (state_q == pndf_pkg::S_EMIT && !dom_q) begin
			pend_q     <= pi_q;
			pend_idx_q <= i_q;
		end
		if (emit_mid || emit_last) begin
			result.point_index <= IW'(pend_idx_q);
			result.out_obj_0   <= pend_q.obj[0];
			result.out_obj_1   <= pend_q.obj[1];
			result.out_obj_2   <= pend_q.obj[2];
			result.out_obj_3   <= pend_q.obj[3];
			result.out_obj_4   <= pend_q.obj[4];
			result.out_obj_5   <= pend_q.obj[5];
			result.out_obj_6   <= pend_q.obj[6];
			result.out_obj_7   <= pend_q.obj[7];
			result.out_tag     <= pend_q.tag;
			result.last_result <= emit_last;
		end
	end

	// a population end always sends the block into filtering
	a_last_starts_filter: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && point.last_point |=> busy)
		else $error("last point beat did not start filtering");

	// final beat of a front only once filtering has ended
	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_result |-> state_q == pndf_pkg::S_IDLE)
		else $error("final result beat while still filtering");

	// a non-final beat always leaves a successor pending
	a_mid_has_successor: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> pend_v_q)
		else $error("non-final result beat with nothing pending");

	// challenger addresses stay inside the loaded population
	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pndf_pkg::S_SWEEP |-> CW'(j_q) < count_q)
		else $error("sweep address beyond loaded points");

	// point count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(pndf_pkg::POP_MAX))
		else $error("point count overflow");

endmodule

`default_nettype wire

// ===== rtl/pndf_store.sv =====
// point store: one write port, one read port with registered read data
// depends on pndf_pkg
`default_nettype none

module pndf_store (
	input  wire logic                  clk,
	input  wire pndf_pkg::store_req_t  req,
	input  wire pndf_pkg::entry_t      wr_data,
	output pndf_pkg::entry_t           rd_data
);

	pndf_pkg::entry_t mem [pndf_pkg::POP_MAX];
	pndf_pkg::entry_t rd_data_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_s1 <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_s1;

endmodule

`default_nettype wire

// ===== rtl/pndf_dom_cmp.sv =====
// dominance test: one lane per objective, signed compare, minimization
// depends on pndf_pkg
`default_nettype none

module pndf_dom_cmp (
	input  wire pndf_pkg::entry_t           cand,
	input  wire pndf_pkg::entry_t           ref_pt,
	input  wire logic [pndf_pkg::NOBJ_W-1:0] n_obj,
	output logic                            dom
);

	localparam int unsigned NW = pndf_pkg::NOBJ_W;

	logic [pndf_pkg::MAX_OBJ-1:0] le;
	logic [pndf_pkg::MAX_OBJ-1:0] lt;

	always_comb begin
		for (int k = 0; k < pndf_pkg::MAX_OBJ; k++) begin
			if (NW'(k) < n_obj) begin
				le[k] = $signed(cand.obj[k]) <= $signed(ref_pt.obj[k]);
				lt[k] = $signed(cand.obj[k]) <  $signed(ref_pt.obj[k]);
			end else begin
				le[k] = 1'b1;
				lt[k] = 1'b0;
			end
		end
	end

	assign dom = (&le) && (|lt);

endmodule

`default_nettype wire
